[rtl/spm_pkg.sv]
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants for the stream pattern matcher.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int BYTE_W    = 8;
  localparam int PAT_W     = 64;
  localparam int LEN_W     = 4;
  localparam int OFFSET_W  = 32;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 64;

  // Register map, indexed by paddr[3] (registers sit 8 bytes apart)
  typedef enum logic {
    REG_PATTERN = 1'b0,
    REG_LENGTH  = 1'b1
  } reg_idx_t;

  localparam logic [PAT_W-1:0] PATTERN_RESET = 64'h0000_004B_434F_4C42; // "BLOCK"
  localparam logic [LEN_W-1:0] LENGTH_RESET  = 4'd5;

  // Per-cycle control broadcast to every window cell
  typedef struct packed {
    logic shift;   // a byte transfer moves the window one place
    logic flush;   // drop the whole history (register write)
  } cell_ctrl_t;

endpackage

[rtl/spm_cell.sv]
// ----------------------------------------------------------------------------
// spm_cell
// One window slot: holds a past byte, compares the byte entering it
// against its aligned pattern byte, and passes its byte to the next slot.
// ----------------------------------------------------------------------------
module spm_cell
  import spm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [BYTE_W-1:0] din,
  input  logic              din_valid,
  input  logic [BYTE_W-1:0] ref_byte,
  input  logic              use_cell,
  output logic [BYTE_W-1:0] q,
  output logic              q_valid,
  output logic              hit
);

  // unused slots always agree
  assign hit = !use_cell || (din_valid && (din == ref_byte));

  always_ff @(posedge clk) begin
    if (rst || ctrl.flush) begin
      q_valid <= 1'b0;
    end else if (ctrl.shift) begin
      q_valid <= din_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q <= din;
    end
  end

endmodule

[rtl/stream_pattern_matcher_top.sv]
// ----------------------------------------------------------------------------
// stream_pattern_matcher_top
// Streaming marker search (prefix-function semantics, overlapping hits)
// built as a shift window of compare cells.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | transfer when
//  --------+-------------------------------------------+----------------------
//  in      | in_valid, in_ready, data_byte,            | in_valid & in_ready
//          | start_of_buffer                           |
//  out     | out_valid, out_ready, match_end_offset    | out_valid & out_ready
//  cfg     | psel, penable, pwrite, paddr, pwdata,     | psel & penable &
//          | prdata, pready                            | pwrite (pready = 1)
//
// One input byte per cycle while in_ready is high; the match decision for a
// byte is made in the cycle it transfers, and its result goes to the output
// register, or to the skid register behind it while a result is held there,
// so the input keeps moving; in_ready drops only when both registers hold.
// Synchronous active-high reset loads the default pattern "BLOCK" with
// length 5, empties the window and clears the position counter.
// Register writes keep the position but empty the window.
// ----------------------------------------------------------------------------
module stream_pattern_matcher_top
  import spm_pkg::*;
#(
  parameter int MAX_PATTERN_LENGTH = 8,
  parameter int POSITION_WIDTH     = 32
) (
  input  logic                clk,
  input  logic                rst,
  // byte stream
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   data_byte,
  input  logic                start_of_buffer,
  // match offsets
  output logic                out_valid,
  input  logic                out_ready,
  output logic [OFFSET_W-1:0] match_end_offset,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  localparam int N      = MAX_PATTERN_LENGTH;
  localparam int EL_W   = $clog2(N + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(N);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [PAT_W-1:0] search_pattern;
  logic [LEN_W-1:0] pattern_length;
  logic             cfg_wr;
  reg_idx_t         cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = reg_idx_t'(paddr[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      search_pattern <= PATTERN_RESET;
      pattern_length <= LENGTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_PATTERN: search_pattern <= pwdata;
        REG_LENGTH:  pattern_length <= pwdata[LEN_W-1:0];
        default:     search_pattern <= search_pattern;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PATTERN: prdata = search_pattern;
      REG_LENGTH:  prdata = {{(PDATA_W-LEN_W){1'b0}}, pattern_length};
      default:     prdata = '0;
    endcase
  end

  // Effective length: 0 acts as 1, anything above the maximum is clamped
  logic [LEN_W-1:0] len_clamp;
  logic [EL_W-1:0]  len_eff;
  logic [2:0]       len_m1;

  always_comb begin
    if (pattern_length == '0) begin
      len_clamp = LEN_W'(1);
    end else if (pattern_length > LEN_MAX) begin
      len_clamp = LEN_MAX;
    end else begin
      len_clamp = pattern_length;
    end
  end

  assign len_eff = len_clamp[EL_W-1:0];
  assign len_m1  = 3'(len_clamp - LEN_W'(1));

  // --------------------------------------------------------------------------
  // Compare window. Cell k sees the byte that entered k transfers ago
  // (cell 0 sees the incoming byte) and checks it against pattern byte
  // len-1-k. All cells agreeing means the pattern ends on this byte.
  // A start flag hides the history from the current byte.
  // --------------------------------------------------------------------------
  logic             in_fire;
  cell_ctrl_t       ctrl;
  logic [BYTE_W-1:0] cell_din   [N];
  logic              cell_dinv  [N];
  logic [BYTE_W-1:0] cell_q     [N];
  logic              cell_qv    [N];
  logic [N-1:0]      cell_hit;

  assign in_fire    = in_valid && in_ready;
  assign ctrl.shift = in_fire;
  assign ctrl.flush = cfg_wr;

  for (genvar k = 0; k < N; k++) begin : g_cell
    logic [2:0]        ref_idx;
    logic [BYTE_W-1:0] ref_byte;
    logic              use_cell;

    assign ref_idx  = 3'(len_m1 - 3'(k));
    assign ref_byte = search_pattern[ref_idx*BYTE_W +: BYTE_W];
    assign use_cell = (EL_W'(k) < len_eff);

    if (k == 0) begin : g_head
      assign cell_din[k]  = data_byte;
      assign cell_dinv[k] = 1'b1;
    end else begin : g_body
      assign cell_din[k]  = cell_q[k-1];
      assign cell_dinv[k] = cell_qv[k-1] && !start_of_buffer;
    end

    spm_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .din       (cell_din[k]),
      .din_valid (cell_dinv[k]),
      .ref_byte  (ref_byte),
      .use_cell  (use_cell),
      .q         (cell_q[k]),
      .q_valid   (cell_qv[k]),
      .hit       (cell_hit[k])
    );
  end

  logic match;
  assign match = &cell_hit;

  // --------------------------------------------------------------------------
  // Byte position: restarts on the start flag, saturates at all ones
  // --------------------------------------------------------------------------
  logic [POSITION_WIDTH-1:0] byte_position;
  logic [POSITION_WIDTH-1:0] pos_base;
  logic [POSITION_WIDTH-1:0] byte_position_next;
  logic [OFFSET_W-1:0]       offset;

  assign pos_base = start_of_buffer ? '0 : byte_position;
  assign byte_position_next = (&pos_base) ? pos_base : pos_base + POSITION_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (in_fire) begin
      byte_position <= byte_position_next;
    end
  end

  if (POSITION_WIDTH > OFFSET_W) begin : g_off_sat
    assign offset = (|byte_position_next[POSITION_WIDTH-1:OFFSET_W]) ? '1
                                                                 : byte_position_next[OFFSET_W-1:0];
  end else if (POSITION_WIDTH == OFFSET_W) begin : g_off_eq
    assign offset = byte_position_next;
  end else begin : g_off_ext
    assign offset = {{(OFFSET_W-POSITION_WIDTH){1'b0}}, byte_position_next};
  end

  // --------------------------------------------------------------------------
  // Output register plus skid register
  // --------------------------------------------------------------------------
  logic                push;
  logic                pop;
  logic                skid_valid;
  logic [OFFSET_W-1:0] skid_offset;

  assign in_ready = !skid_valid;
  assign push     = in_fire && match;
  assign pop      = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;          // skid drains; no push possible now
      end else begin
        out_valid  <= push;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      match_end_offset <= skid_offset;
    end else if (push && (pop || !out_valid)) begin
      match_end_offset <= offset;
    end
    if (push && out_valid && !pop) begin
      skid_offset <= offset;
    end
  end

endmodule

[sim/stream_pattern_matcher_top_tb.sv]
// ----------------------------------------------------------------------------
// stream_pattern_matcher_top_tb
// Self-checking bench: byte stream in, match offsets out, both valid/ready,
// plus register writes over the APB-style port. A prefix-function predictor
// tracks the block and queues the offsets it expects; every output transfer
// is checked against the oldest one. A short directed table comes first,
// then random streams under a series of pattern settings.
// ----------------------------------------------------------------------------
module stream_pattern_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spm_pkg::*;

  localparam int MAX_LEN         = 8;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 153;
  localparam int HOLD_CYCLES     = 80;   // long receiver hold-off
  localparam int SETTLE_CYCLES   = 3;    // result register + skid, plus margin
  localparam int TAIL_CYCLES     = 10;

  // marker letters of the default pattern, plus a filler letter
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_O = 8'h4F;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_K = 8'h4B;
  localparam logic [7:0] CH_A = 8'h41;

  localparam logic [PAT_W-1:0] PAT_ABAB = 64'h4241_4241_4241_4241;

  // ---------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                clk;
  logic                rst             = 1'b1;
  logic                in_valid        = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   data_byte       = '0;
  logic                start_of_buffer = 1'b0;
  logic                out_valid;
  logic                out_ready       = 1'b0;
  logic [OFFSET_W-1:0] match_end_offset;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [PADDR_W-1:0]  paddr           = '0;
  logic [PDATA_W-1:0]  pwdata          = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  stream_pattern_matcher_top dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: registers, fallback table, partial match, position
  // ---------------------------------------------------------------------------
  logic [PAT_W-1:0]    exp_pattern;
  logic [LEN_W-1:0]    exp_len_reg;
  int unsigned         exp_fallback [MAX_LEN];
  int unsigned         exp_partial;
  logic [OFFSET_W-1:0] exp_position;

  logic [OFFSET_W-1:0] pending_offsets [$];  // offsets still owed by the block
  int                  errors = 0;

  bit steady_run = 1'b0;  // both sides stop idling
  bit hold_go    = 1'b0;  // ask receiver for the long hold-off
  int hold_left  = 0;

  // out-of-range length codes clamp to 1..8
  function automatic int unsigned active_length();
    if (exp_len_reg == 0) return 1;
    if (exp_len_reg > MAX_LEN) return MAX_LEN;
    return int'(exp_len_reg);
  endfunction

  function automatic logic [7:0] pat_byte(int unsigned k);
    return exp_pattern[8*(k % MAX_LEN) +: 8];
  endfunction

  // prefix function of the active pattern; any register write also drops
  // the partial match but keeps the position
  function automatic void rebuild_fallback();
    int unsigned n, i, m;
    n = active_length();
    m = 0;
    for (i = 0; i < MAX_LEN; i++) exp_fallback[i] = 0;
    for (i = 1; i < n; i++) begin
      while (m > 0 && pat_byte(m) != pat_byte(i)) m = exp_fallback[m-1];
      if (pat_byte(m) == pat_byte(i)) m++;
      exp_fallback[i] = m;
    end
    exp_partial = 0;
  endfunction

  function automatic void apply_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
    case (idx)
      REG_PATTERN: exp_pattern = value;
      REG_LENGTH:  exp_len_reg = value[LEN_W-1:0];
      default:     ;
    endcase
    rebuild_fallback();
  endfunction

  // advance the matcher by one byte; returns 1 with the offset on a full match
  function automatic bit predict_offset(input logic [7:0] value, input logic sob,
                                        output logic [OFFSET_W-1:0] off);
    int unsigned n, m;
    n   = active_length();
    off = '0;
    if (sob) begin
      exp_partial  = 0;
      exp_position = '0;
    end
    if (exp_position != '1) exp_position++;
    m = exp_partial;
    if (m >= n) m = 0;
    while (m > 0 && pat_byte(m) != value) m = exp_fallback[m-1];
    if (pat_byte(m) == value) m++;
    if (m >= n) begin
      off         = exp_position;
      exp_partial = exp_fallback[n-1];  // fall back so overlaps are found
      return 1'b1;
    end
    exp_partial = m;
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: random gap (none in a steady run), then hold the byte until the transfer
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic sob,
                           input bit typed = 1'b0, input bit typed_hit = 1'b0,
                           input logic [OFFSET_W-1:0] typed_off = '0);
    logic [OFFSET_W-1:0] off;
    bit hit;
    if (!steady_run)
      while ($urandom_range(0, 99) < 25) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid        <= 1'b1;
    data_byte       <= value;
    start_of_buffer <= sob;
    do @(posedge clk); while (!in_ready);
    hit = predict_offset(value, sob, off);
    // rows with a hand-written answer override the predictor's
    if (typed) begin
      hit = typed_hit;
      off = typed_off;
    end
    if (hit) pending_offsets = {pending_offsets, off};
  endtask

  // stop sending and let every owed result drain before touching registers
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle, then access cycle; the write lands at the access edge
  task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    apply_register(idx, value);
    @(posedge clk);
  endtask

  // random stream, mostly bytes drawn from the pattern so that long partial
  // matches, fallbacks and overlaps are common; some whole copies injected
  task automatic stream_phase(input int count);
    int unsigned n, k;
    int sent;
    logic [7:0] b;
    n    = active_length();
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 99) < 10) begin
        for (k = 0; k < n && sent < count; k++) begin
          send_byte(pat_byte(k), (k == 0) && ($urandom_range(0, 99) < 20));
          sent++;
        end
      end else begin
        if ($urandom_range(0, 99) < 65) b = pat_byte($urandom_range(0, n - 1));
        else b = 8'($urandom_range(0, 255));
        send_byte(b, $urandom_range(0, 99) < 3);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Directed table, run against the reset pattern "BLOCK"
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [7:0]          data;
    logic                sob;
    logic                typed;   // expectation written by hand
    logic                hit;
    logic [OFFSET_W-1:0] offset;
  } scan_row_t;

  localparam int DIR_ROWS = 25;

  scan_row_t dir_rows [DIR_ROWS] = '{
    // plain match right after reset
    '{CH_B, 1'b1, 1'b1, 1'b0, 32'd0},
    '{CH_L, 1'b0, 1'b1, 1'b0, 32'd0},
    '{CH_O, 1'b0, 1'b1, 1'b0, 32'd0},
    '{CH_C, 1'b0, 1'b1, 1'b0, 32'd0},
    '{CH_K, 1'b0, 1'b1, 1'b1, 32'd5},
    // byte extremes
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'd0},
    '{8'hFF, 1'b0, 1'b0, 1'b0, 32'd0},
    // new buffer restarts the offset count
    '{CH_B, 1'b1, 1'b1, 1'b0, 32'd0},
    '{CH_L, 1'b0, 1'b1, 1'b0, 32'd0},
    '{CH_O, 1'b0, 1'b1, 1'b0, 32'd0},
    '{CH_C, 1'b0, 1'b1, 1'b0, 32'd0},
    '{CH_K, 1'b0, 1'b1, 1'b1, 32'd5},
    // broken prefix, then recovery through the fallback
    '{CH_B, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_L, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_B, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_L, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_O, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_C, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_K, 1'b0, 1'b0, 1'b0, 32'd0},
    // start flag in the middle of a partial match
    '{CH_B, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_L, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_O, 1'b1, 1'b0, 1'b0, 32'd0},
    // leave "BLO" open; the register write that follows must drop it
    '{CH_B, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_L, 1'b0, 1'b0, 1'b0, 32'd0},
    '{CH_O, 1'b0, 1'b0, 1'b0, 32'd0}
  };

  // ---------------------------------------------------------------------------
  // Receiver: random ready, steady stretch, and one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_left = HOLD_CYCLES;
        hold_go   = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (steady_run) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 25);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: every output transfer against the oldest owed offset
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input logic [OFFSET_W-1:0] want,
                               input logic [OFFSET_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  always @(posedge clk) begin : check_results
    logic [OFFSET_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_offsets.size() == 0) begin
        note_mismatch("no result pending", '0, match_end_offset);
      end else begin
        want = pending_offsets.pop_front();
        if (match_end_offset !== want) note_mismatch("match_end_offset", want, match_end_offset);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    logic [PAT_W-1:0] pat;
    logic [LEN_W-1:0] len;
    int i, ph, k;

    // predictor starts from the reset pattern
    exp_pattern  = PATTERN_RESET;
    exp_len_reg  = LENGTH_RESET;
    exp_position = '0;
    rebuild_fallback();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < DIR_ROWS; i++)
      send_byte(dir_rows[i].data, dir_rows[i].sob, dir_rows[i].typed,
                dir_rows[i].hit, dir_rows[i].offset);

    // rewrite the same pattern: "BLO" is dropped, so "CK" must not match,
    // and the position keeps counting
    settle_block();
    write_reg(REG_PATTERN, PATTERN_RESET);
    write_reg(REG_LENGTH, {{(PDATA_W-LEN_W){1'b0}}, LENGTH_RESET});
    send_byte(CH_C, 1'b0);
    send_byte(CH_K, 1'b0);

    for (ph = 1; ph <= NUM_PHASES; ph++) begin
      settle_block();
      case (ph)
        1: begin pat = '0;       len = 4'd1;  end   // every zero byte hits
        2: begin pat = '1;       len = 4'd15; end   // length above max clamps to 8
        3: begin pat = PAT_ABAB; len = 4'd0;  end   // length zero acts as one
        4: begin pat = PAT_ABAB; len = 4'd8;  end   // deep self-overlap
        5, 9: begin
          // two-letter patterns give rich fallback tables
          for (k = 0; k < MAX_LEN; k++)
            pat[8*k +: 8] = $urandom_range(0, 1) ? CH_A : CH_B;
          len = LEN_W'($urandom_range(0, 15));
        end
        default: begin
          pat = {$urandom, $urandom};
          len = LEN_W'($urandom_range(0, 15));
        end
      endcase
      write_reg(REG_PATTERN, pat);
      write_reg(REG_LENGTH, {{(PDATA_W-LEN_W){1'b0}}, len});
      steady_run = (ph == 4);
      // a hit on most bytes fills the output stage under the hold-off
      if (ph == 1) hold_go = 1'b1;
      stream_phase(ITEMS_PER_PHASE);
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #400_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
